// ===== rtl/utf8d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the strict UTF-8 decoder.
// No dependencies; imported by utf8d_decode and utf8_validating_decoder_unit.
package utf8d_pkg;

   localparam int unsigned RSP_DEPTH = 4;

   localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
   localparam logic [7:0]  CONT_LOW_DEFAULT  = 8'h80;
   localparam logic [7:0]  CONT_HIGH_DEFAULT = 8'hBF;
   localparam logic [7:0]  LEAD2_MIN = 8'hC2;
   localparam logic [7:0]  LEAD2_MAX = 8'hDF;
   localparam logic [7:0]  LEAD3_E0  = 8'hE0;
   localparam logic [7:0]  LEAD3_ED  = 8'hED;
   localparam logic [7:0]  LEAD4_MIN = 8'hF0;
   localparam logic [7:0]  LEAD4_MAX = 8'hF4;
   localparam logic [7:0]  E0_LOW    = 8'hA0;
   localparam logic [7:0]  ED_HIGH   = 8'h9F;
   localparam logic [7:0]  F0_LOW    = 8'h90;
   localparam logic [7:0]  F4_HIGH   = 8'h8F;
   localparam logic [7:0]  CONT_MASK = 8'h3F;
   localparam logic [7:0]  LEAD4_MASK = 8'h07;

   typedef struct packed {
      logic        text_end;
      logic        run_last;
      logic [2:0]  byte_count;
      logic        well_formed;
      logic [20:0] code_point;
   } result_type;

   typedef struct packed {
      logic [20:0] partial_value;
      logic [1:0]  bytes_taken;
      logic [1:0]  bytes_still_needed;
      logic [7:0]  next_low_bound;
      logic [7:0]  next_high_bound;
   } dec_state_type;

   localparam dec_state_type IDLE_STATE = '{
      partial_value:      21'd0,
      bytes_taken:        2'd0,
      bytes_still_needed: 2'd0,
      next_low_bound:     CONT_LOW_DEFAULT,
      next_high_bound:    CONT_HIGH_DEFAULT
   };

endpackage

// ===== rtl/utf8d_decode.sv =====
`timescale 1ns / 1ps
// One-byte decode step: range checks, value shift and up to two results.
// Depends on utf8d_pkg.
module utf8d_decode
   import utf8d_pkg::*;
(
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   input  dec_state_type state_cur,
   output dec_state_type state_next,
   output result_type    res_first,
   output result_type    res_second,
   output logic [1:0]    res_count
);

   logic          lead2;
   logic          lead3;
   logic          lead4;
   logic          lead_multi;
   logic          lead_emits;
   result_type    lead_res;
   dec_state_type lead_state;
   logic          pending;
   logic          in_range;
   logic [2:0]    cnt;
   logic [20:0]   acc;

   always_comb begin
      lead2      = (in_byte >= LEAD2_MIN) && (in_byte <= LEAD2_MAX);
      lead3      = (in_byte[7:4] == LEAD3_E0[7:4]);
      lead4      = (in_byte >= LEAD4_MIN) && (in_byte <= LEAD4_MAX);
      lead_multi = lead2 || lead3 || lead4;
      // a lead that opens a sequence stays silent unless the text ends here
      lead_emits = !lead_multi || in_last;

      lead_res = '0;
      lead_res.byte_count = 3'd1;
      if (!in_byte[7]) begin
         lead_res.code_point  = {13'd0, in_byte};
         lead_res.well_formed = 1'b1;
      end else begin
         lead_res.code_point  = REPLACEMENT_CHAR;
         lead_res.well_formed = 1'b0;
      end

      lead_state = IDLE_STATE;
      if (lead_multi && !in_last) begin
         lead_state.bytes_taken = 2'd1;
         if (lead2) begin
            lead_state.partial_value      = {16'd0, in_byte[4:0]};
            lead_state.bytes_still_needed = 2'd1;
         end else if (lead3) begin
            lead_state.partial_value      = {17'd0, in_byte[3:0]};
            lead_state.bytes_still_needed = 2'd2;
            if (in_byte == LEAD3_E0) lead_state.next_low_bound = E0_LOW;
            if (in_byte == LEAD3_ED) lead_state.next_high_bound = ED_HIGH;
         end else begin
            lead_state.partial_value      = {18'd0, in_byte[2:0] & LEAD4_MASK[2:0]};
            lead_state.bytes_still_needed = 2'd3;
            if (in_byte == LEAD4_MIN) lead_state.next_low_bound = F0_LOW;
            if (in_byte == LEAD4_MAX) lead_state.next_high_bound = F4_HIGH;
         end
      end

      pending  = (state_cur.bytes_still_needed != 2'd0);
      in_range = (in_byte >= state_cur.next_low_bound) &&
                 (in_byte <= state_cur.next_high_bound);
      cnt      = {1'b0, state_cur.bytes_taken} + 3'd1;
      acc      = {state_cur.partial_value[14:0], in_byte[5:0] & CONT_MASK[5:0]};

      state_next = lead_state;
      res_first  = lead_res;
      res_second = lead_res;
      res_count  = 2'd0;

      if (pending && in_range) begin
         // accepted continuation: extend, finish, or cut short at end of text
         state_next                    = IDLE_STATE;
         state_next.partial_value      = acc;
         state_next.bytes_taken        = cnt[1:0];
         state_next.bytes_still_needed = state_cur.bytes_still_needed - 2'd1;
         res_first            = '0;
         res_first.byte_count = cnt;
         if (state_cur.bytes_still_needed == 2'd1) begin
            res_first.code_point  = acc;
            res_first.well_formed = 1'b1;
            res_count             = 2'd1;
            state_next            = IDLE_STATE;
         end else if (in_last) begin
            res_first.code_point  = REPLACEMENT_CHAR;
            res_first.well_formed = 1'b0;
            res_count             = 2'd1;
         end
      end else if (pending) begin
         // rejected continuation: close the pending run, then retry as a lead
         res_first             = '0;
         res_first.code_point  = REPLACEMENT_CHAR;
         res_first.byte_count  = {1'b0, state_cur.bytes_taken};
         res_count             = lead_emits ? 2'd2 : 2'd1;
      end else begin
         res_count = lead_emits ? 2'd1 : 2'd0;
      end

      if (res_count == 2'd1) begin
         res_first.run_last = 1'b1;
         res_first.text_end = in_last;
      end
      if (res_count == 2'd2) begin
         res_second.run_last = 1'b1;
         res_second.text_end = in_last;
      end

      if (in_last) state_next = IDLE_STATE;
   end

endmodule

// ===== rtl/utf8_validating_decoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the strict UTF-8 decoder: input register, decode step, result queue.
// Depends on utf8d_pkg and utf8d_decode.

// Takes UTF-8 text one byte per request (req_tlast marks the final byte of a
// text) and returns decoded code points on the rsp_ stream. Validation is
// strict: overlong forms, surrogates and values above U+10FFFF are rejected
// per the Unicode table of well-formed sequences; each ill-formed maximal
// subpart comes out as U+FFFD with well_formed low and the number of bytes it
// covers. A byte that breaks a pending sequence yields the error for that
// sequence and is then decoded as a new lead, so one request can give two
// results; a byte that only extends a sequence gives none. run_last flags the
// last result of each request and rsp_tlast the last result of a text, after
// which the decoder is back in its reset state. Requests are registered before
// decoding. The block takes one byte per cycle; the decode step moves a byte
// from the input register into the result queue once the queue has room for
// two results, so only a consumer that takes results slower than they come,
// or a run of two-result bytes, slows the input down.
module utf8_validating_decoder_unit
   import utf8d_pkg::*;
#(
   parameter int unsigned Depth = RSP_DEPTH   // result queue entries, at least 3
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // in_last
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [20:0] code_point, [21] well_formed,
                                     // [24:22] byte_count, [25] run_last, zero above
   output logic        rsp_tlast     // text_end
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] RoomLimit = CntW'(Depth - 2);

   // input register
   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;

   // decoder state
   dec_state_type state_ff;
   dec_state_type state_in;

   // decode step outputs
   result_type    res_first;
   result_type    res_second;
   logic [1:0]    res_count;
   logic          step_fire;

   // result queue
   result_type    queue_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] wr_ptr_next;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            pop;
   result_type      head;

   utf8d_decode u_decode (
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .res_first  (res_first),
      .res_second (res_second),
      .res_count  (res_count)
   );

   // advance the held byte only when the queue can absorb a two-result step
   assign step_fire  = in_valid_ff && (count_ff <= RoomLimit);
   assign req_tready = !in_valid_ff || step_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_STATE;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // queue pointers: wrap at the configured depth
   always_comb begin
      pop         = rsp_tvalid && rsp_tready;
      wr_ptr_next = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      wr_ptr_in   = wr_ptr_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      if (step_fire) begin
         case (res_count)
            2'd1: begin
               wr_ptr_in = wr_ptr_next;
            end
            2'd2: begin
               wr_ptr_in = (wr_ptr_next == LastPtr) ? '0 : wr_ptr_next + PtrW'(1);
            end
            default: begin
               wr_ptr_in = wr_ptr_ff;
            end
         endcase
         count_in = count_ff + CntW'(res_count);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
         count_in  = count_in - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // push the first result at the write pointer, the second one slot after it
   always_ff @(posedge clock) begin
      if (step_fire && (res_count != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res_first;
      end
      if (step_fire && (res_count == 2'd2)) begin
         queue_ff[wr_ptr_next] <= res_second;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {6'd0, head.run_last, head.byte_count,
                        head.well_formed, head.code_point};
   assign rsp_tlast  = head.text_end;

endmodule
